// ===== rtl/tet_pkg.sv =====
package tet_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SCAN_W      = $clog2(TABLE_DEPTH + 1);
   localparam int MAX_OUT     = 32;
   localparam int CNT_W       = $clog2(MAX_OUT + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_TICK   = 2'd1,
      KIND_REMOVE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STAT_INSERTED     = 3'd0,
      STAT_FULL         = 3'd1,
      STAT_REMOVED      = 3'd2,
      STAT_EXPIRED      = 3'd3,
      STAT_NONE_EXPIRED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_INSERT,
      BK_SCAN,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic [31:0]        time_value;
      logic [7:0]         delay_type;
      logic [7:0]         effect_type;
      logic [15:0]        target_handle;
      logic [7:0]         target_type;
      logic [7:0]         map_index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [31:0] arg_one;
      logic signed [31:0] arg_two;
      logic signed [31:0] arg_three;
   } record_type;

   typedef struct packed {
      kind_type   kind;
      record_type rec;
   } cmd_type;

   typedef struct packed {
      status_type         status;
      logic [7:0]         delay_type;
      logic [7:0]         effect_type;
      logic [15:0]        target_handle;
      logic [7:0]         target_type;
      logic [7:0]         map_index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [31:0] arg_one;
      logic signed [31:0] arg_two;
      logic signed [31:0] arg_three;
      logic               last;
   } result_type;

   function automatic result_type to_result(record_type r, status_type s, logic l);
      result_type res;
      res.status        = s;
      res.delay_type    = r.delay_type;
      res.effect_type   = r.effect_type;
      res.target_handle = r.target_handle;
      res.target_type   = r.target_type;
      res.map_index     = r.map_index;
      res.pos_x         = r.pos_x;
      res.pos_y         = r.pos_y;
      res.arg_one       = r.arg_one;
      res.arg_two       = r.arg_two;
      res.arg_three     = r.arg_three;
      res.last          = l;
      return res;
   endfunction

   function automatic result_type simple_result(status_type s);
      result_type res;
      res        = '0;
      res.status = s;
      res.last   = 1'b1;
      return res;
   endfunction

endpackage

// ===== rtl/tet_front.sv =====
module tet_front (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [31:0]        req_time_value,
   input  logic [7:0]         req_delay_type,
   input  logic [7:0]         req_effect_type,
   input  logic [15:0]        req_target_handle,
   input  logic [7:0]         req_target_type,
   input  logic [7:0]         req_map_index,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [31:0] req_arg_one,
   input  logic signed [31:0] req_arg_two,
   input  logic signed [31:0] req_arg_three,
   output logic               push_valid,
   input  logic               push_ready,
   output tet_pkg::cmd_type   push_data
);
   import tet_pkg::*;

   logic kind_known;

   assign kind_known = (req_kind == KIND_INSERT) || (req_kind == KIND_TICK) ||
                       (req_kind == KIND_REMOVE);

   // drop unknown kinds at the door; they still complete their transaction
   assign req_ready  = push_ready;
   assign push_valid = req_valid && kind_known;

   always_comb begin
      push_data.kind              = kind_type'(req_kind);
      push_data.rec.time_value    = req_time_value;
      push_data.rec.delay_type    = req_delay_type;
      push_data.rec.effect_type   = req_effect_type;
      push_data.rec.target_handle = req_target_handle;
      push_data.rec.target_type   = req_target_type;
      push_data.rec.map_index     = req_map_index;
      push_data.rec.pos_x         = req_pos_x;
      push_data.rec.pos_y         = req_pos_y;
      push_data.rec.arg_one       = req_arg_one;
      push_data.rec.arg_two       = req_arg_two;
      push_data.rec.arg_three     = req_arg_three;
   end

endmodule

// ===== rtl/tet_queue.sv =====
module tet_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  tet_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output tet_pkg::cmd_type pop_data
);
   import tet_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/tet_back.sv =====
module tet_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  tet_pkg::cmd_type    cmd_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tet_pkg::result_type rsp_data
);
   import tet_pkg::*;

   back_state_type       state_ff, state_in;
   cmd_type              cur_ff, cur_in;
   record_type           mem [TABLE_DEPTH];
   record_type           rd_data_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [SCAN_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                 s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]     s1_idx_ff, s1_idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 pend_vld_ff, pend_vld_in;
   result_type           pend_ff, pend_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   result_type           rsp_ff, rsp_in;
   logic                 can_push, push;
   result_type           push_data;
   logic                 rd_en, wr_en;
   logic                 free_found;
   logic [IDX_W-1:0]     free_idx;
   logic                 scan_end, advance, stall, tick_hit, rm_hit;

   assign cmd_ready = state_ff == BK_IDLE;
   assign can_push  = !rsp_vld_ff || rsp_ready;
   assign scan_end  = scan_idx_ff == SCAN_W'(TABLE_DEPTH);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign tick_hit = s1_vld_ff && (cur_ff.kind == KIND_TICK) && valid_ff[s1_idx_ff] &&
                     (rd_data_ff.time_value < cur_ff.rec.time_value) &&
                     (cnt_ff < CNT_W'(MAX_OUT));
   assign rm_hit   = s1_vld_ff && (cur_ff.kind == KIND_REMOVE) && valid_ff[s1_idx_ff] &&
                     (rd_data_ff.target_handle == cur_ff.rec.target_handle) &&
                     (rd_data_ff.target_type == cur_ff.rec.target_type) &&
                     ((cur_ff.rec.effect_type == '0) ||
                      (rd_data_ff.effect_type == cur_ff.rec.effect_type));
   // hold the scan when a second hit finds the output still occupied
   assign stall    = tick_hit && pend_vld_ff && !can_push;
   assign advance  = (state_ff == BK_SCAN) && !stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               state_in = (cmd_data.kind == KIND_INSERT) ? BK_INSERT : BK_SCAN;
            end
         end
         BK_INSERT: begin
            if (can_push) state_in = BK_IDLE;
         end
         BK_SCAN: begin
            if (scan_end && !s1_vld_ff) state_in = BK_FINISH;
         end
         BK_FINISH: begin
            if (can_push) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cur_in      = cur_ff;
      valid_in    = valid_ff;
      scan_idx_in = scan_idx_ff;
      s1_vld_in   = s1_vld_ff;
      s1_idx_in   = s1_idx_ff;
      cnt_in      = cnt_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      push        = 1'b0;
      push_data   = pend_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cur_in      = cmd_data;
               scan_idx_in = '0;
               s1_vld_in   = 1'b0;
               cnt_in      = '0;
               pend_vld_in = 1'b0;
            end
         end
         BK_INSERT: begin
            if (can_push) begin
               push      = 1'b1;
               push_data = simple_result(free_found ? STAT_INSERTED : STAT_FULL);
               if (free_found) begin
                  wr_en              = 1'b1;
                  valid_in[free_idx] = 1'b1;
               end
            end
         end
         BK_SCAN: begin
            if (advance) begin
               rd_en     = !scan_end;
               s1_vld_in = !scan_end;
               s1_idx_in = scan_idx_ff[IDX_W-1:0];
               if (!scan_end) scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (tick_hit && !stall) begin
               valid_in[s1_idx_ff] = 1'b0;
               pend_in             = to_result(rd_data_ff, STAT_EXPIRED, 1'b0);
               pend_vld_in         = 1'b1;
               cnt_in              = cnt_ff + 1'b1;
               if (pend_vld_ff) begin
                  push      = 1'b1;
                  push_data = pend_ff;
               end
            end
            if (rm_hit) begin
               valid_in[s1_idx_ff] = 1'b0;
            end
         end
         BK_FINISH: begin
            if (can_push) begin
               push = 1'b1;
               if (cur_ff.kind != KIND_TICK) begin
                  push_data = simple_result(STAT_REMOVED);
               end else if (pend_vld_ff) begin
                  push_data      = pend_ff;
                  push_data.last = 1'b1;
               end else begin
                  push_data = simple_result(STAT_NONE_EXPIRED);
               end
            end
         end
         default: begin
         end
      endcase
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff;
      if (push) begin
         rsp_vld_in = 1'b1;
         rsp_in     = push_data;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         valid_ff    <= '0;
         scan_idx_ff <= '0;
         s1_vld_ff   <= 1'b0;
         cnt_ff      <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         scan_idx_ff <= scan_idx_in;
         s1_vld_ff   <= s1_vld_in;
         cnt_ff      <= cnt_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      s1_idx_ff <= s1_idx_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[free_idx] <= cur_ff.rec;
      end
      if (rd_en) begin
         rd_data_ff <= mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

endmodule

// ===== rtl/timed_event_table_top.sv =====
// Timed event table with TABLE_DEPTH slots. For an insert, the lowest free slot is found
// combinationally from the per-slot valid flags and written once the result side can take
// the status. Tick and remove transactions walk the record memory through its single read
// port, one slot per cycle except while the result side holds off expired entries. A
// two-entry command queue lets the request side keep sending while a scan runs. Reset
// clears all valid flags at once; no clearing pass is needed. Kind 3 requests are accepted
// and dropped without a result.
module timed_event_table_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [31:0]        req_time_value,
   input  logic [7:0]         req_delay_type,
   input  logic [7:0]         req_effect_type,
   input  logic [15:0]        req_target_handle,
   input  logic [7:0]         req_target_type,
   input  logic [7:0]         req_map_index,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [31:0] req_arg_one,
   input  logic signed [31:0] req_arg_two,
   input  logic signed [31:0] req_arg_three,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_out_delay_type,
   output logic [7:0]         rsp_out_effect_type,
   output logic [15:0]        rsp_out_target_handle,
   output logic [7:0]         rsp_out_target_type,
   output logic [7:0]         rsp_out_map_index,
   output logic signed [15:0] rsp_out_pos_x,
   output logic signed [15:0] rsp_out_pos_y,
   output logic signed [31:0] rsp_out_arg_one,
   output logic signed [31:0] rsp_out_arg_two,
   output logic signed [31:0] rsp_out_arg_three,
   output logic               rsp_last
);
   import tet_pkg::*;

   logic       push_valid, push_ready;
   cmd_type    push_data;
   logic       pop_valid, pop_ready;
   cmd_type    pop_data;
   result_type rsp_data;

   tet_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_time_value    (req_time_value),
      .req_delay_type    (req_delay_type),
      .req_effect_type   (req_effect_type),
      .req_target_handle (req_target_handle),
      .req_target_type   (req_target_type),
      .req_map_index     (req_map_index),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_arg_one       (req_arg_one),
      .req_arg_two       (req_arg_two),
      .req_arg_three     (req_arg_three),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_data         (push_data)
   );

   tet_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tet_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_status            = rsp_data.status;
   assign rsp_out_delay_type    = rsp_data.delay_type;
   assign rsp_out_effect_type   = rsp_data.effect_type;
   assign rsp_out_target_handle = rsp_data.target_handle;
   assign rsp_out_target_type   = rsp_data.target_type;
   assign rsp_out_map_index     = rsp_data.map_index;
   assign rsp_out_pos_x         = rsp_data.pos_x;
   assign rsp_out_pos_y         = rsp_data.pos_y;
   assign rsp_out_arg_one       = rsp_data.arg_one;
   assign rsp_out_arg_two       = rsp_data.arg_two;
   assign rsp_out_arg_three     = rsp_data.arg_three;
   assign rsp_last              = rsp_data.last;

endmodule

// ===== rtl/tet_checker.sv =====
module tet_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_status,
   input logic [7:0]         rsp_out_delay_type,
   input logic [15:0]        rsp_out_target_handle,
   input logic signed [15:0] rsp_out_pos_x,
   input logic signed [31:0] rsp_out_arg_one,
   input logic signed [31:0] rsp_out_arg_three,
   input logic               rsp_last
);
   import tet_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   a_simple_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_EXPIRED) |-> rsp_last)
      else $error("non-expiry result without last");

   a_simple_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_EXPIRED) |->
         (rsp_out_delay_type == '0) && (rsp_out_target_handle == '0) &&
         (rsp_out_pos_x == '0) && (rsp_out_arg_one == '0) && (rsp_out_arg_three == '0))
      else $error("non-expiry result carries record data");

endmodule

bind timed_event_table_top tet_checker u_checker (.*);
